@@ hw/rtl/gpib_three_wire_handshake_assert.svh @@
// ----------------------------------------------------------------------------
// GPIB three-wire handshake assertion macros
// Concurrent assertion helpers used by the handshake RTL.
// ----------------------------------------------------------------------------
`ifndef GPIB_THREE_WIRE_HANDSHAKE_ASSERT_SVH
`define GPIB_THREE_WIRE_HANDSHAKE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define GPIB3W_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gpib handshake check failed");

// Next-cycle implication, checked outside reset.
`define GPIB3W_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gpib handshake check failed");

`else

`define GPIB3W_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GPIB3W_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/gpib3w_pkg.sv @@
// ----------------------------------------------------------------------------
// GPIB three-wire handshake package
// Phase codes, bus command codes, status codes, register indexes, reset values and the line drive type.
// ----------------------------------------------------------------------------
`default_nettype none

package gpib3w_pkg;

  // Handshake phases.
  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_RX_DAV_LOW   = 3'd1;
  localparam logic [2:0] PH_RX_DAV_HIGH  = 3'd2;
  localparam logic [2:0] PH_TX_NRFD_HIGH = 3'd3;
  localparam logic [2:0] PH_TX_NRFD_LOW  = 3'd4;
  localparam logic [2:0] PH_TX_NDAC_HIGH = 3'd5;

  // Bus commands received under ATN.
  localparam logic [7:0] CMD_UNLISTEN    = 8'h3F;
  localparam logic [7:0] CMD_UNTALK      = 8'h5F;
  localparam logic [2:0] CMD_LISTEN_GRP  = 3'b001;
  localparam logic [2:0] CMD_TALK_GRP    = 3'b010;

  // Transmit status codes.
  localparam logic [1:0] TX_NONE         = 2'd0;
  localparam logic [1:0] TX_TAKEN        = 2'd1;
  localparam logic [1:0] TX_SENT         = 2'd2;
  localparam logic [1:0] TX_TIMEOUT      = 2'd3;

  // Configuration register indexes.
  localparam logic REG_DEVICE_ADDRESS    = 1'b0;
  localparam logic REG_HANDSHAKE_TIMEOUT = 1'b1;

  localparam logic [4:0]  DEVICE_ADDRESS_RST = 5'd8;
  localparam logic [23:0] TIMEOUT_RST        = 24'd65535;
  localparam logic [7:0]  BUS_RELEASED       = 8'hFF;

  // Open-drain drive levels, 1 releases the line.
  typedef struct packed {
    logic [7:0] bus;
    logic       eoi;
    logic       ndac;
    logic       nrfd;
    logic       dav;
  } line_drives_t;

  localparam line_drives_t LINES_RELEASED = '{bus: 8'hFF, eoi: 1'b1, ndac: 1'b1,
                                              nrfd: 1'b1, dav: 1'b1};

endpackage

`default_nettype wire

@@ hw/rtl/gpib_three_wire_handshake.sv @@
// Path: a transfer in is registered in the input register, then its result is
//   registered in the result register once that register is free to advance.
// Throughput: one tick per cycle while the result side is ready; a stall on
//   out_tready holds the input register and its tick.
// Reset: synchronous, active low; phase idle, flags clear, all lines released,
//   address 8 and timeout 65535.
// ----------------------------------------------------------------------------
// GPIB three-wire handshake device
// Listener and talker handshake engine driven by sampled bus line ticks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gpib_three_wire_handshake_assert.svh"

module gpib_three_wire_handshake
  import gpib3w_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_wdata,
  // Input ticks.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // ifc_line[0], atn_line[1], dav_line[2], nrfd_line[3], ndac_line[4],
  // eoi_line[5], bus_lines[13:6], tx_offer[14], tx_value[22:15], zero fill.
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tlast,   // tx_final
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // dav_drive[0], nrfd_drive[1], ndac_drive[2], eoi_drive[3], bus_drive[11:4],
  // rx_strobe[12], rx_value[20:13], listening[21], talking[22],
  // tx_status[24:23], zero fill.
  output logic [31:0]      out_tdata,
  output logic             out_tlast   // rx_final
);

  localparam int LIM_W = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

  // Configuration registers.
  logic [4:0]  dev_addr_r;
  logic [23:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEVICE_ADDRESS_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEVICE_ADDRESS) begin
        dev_addr_r <= cfg_wdata[4:0];
      end else begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // Input register and output register handshake.
  logic        in_valid_r;
  logic [23:0] in_data_r;
  logic        in_last_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic        advance;
  logic        fire;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Unpack the registered tick.
  logic       ifc_l, atn_l, dav_l, nrfd_l, ndac_l, eoi_l, offer;
  logic [7:0] bus_l, tx_val;

  assign ifc_l  = in_data_r[0];
  assign atn_l  = in_data_r[1];
  assign dav_l  = in_data_r[2];
  assign nrfd_l = in_data_r[3];
  assign ndac_l = in_data_r[4];
  assign eoi_l  = in_data_r[5];
  assign bus_l  = in_data_r[13:6];
  assign offer  = in_data_r[14];
  assign tx_val = in_data_r[22:15];

  // Handshake state.
  logic [2:0]             phase_r, phase_nxt;
  logic                   listen_r, listen_nxt;
  logic                   talk_r, talk_nxt;
  logic                   cmd_mode_r, cmd_mode_nxt;
  logic [COUNT_WIDTH-1:0] wait_count_r, wait_count_nxt;
  logic [7:0]             held_byte_r, held_byte_nxt;
  logic                   held_final_r, held_final_nxt;
  line_drives_t           lines_r, lines_nxt;

  // Wait limit: zero counts as one, clipped to the counter range.
  logic [LIM_W-1:0]       timeout_ext, cmax_ext, limit_ext;
  logic [COUNT_WIDTH-1:0] limit, wait_inc;
  logic                   expired;

  assign timeout_ext = LIM_W'(timeout_r);
  assign cmax_ext    = LIM_W'({COUNT_WIDTH{1'b1}});
  assign limit_ext   = (timeout_ext > cmax_ext) ? cmax_ext : timeout_ext;

  always_comb begin
    limit = limit_ext[COUNT_WIDTH-1:0];
    if (limit == '0) begin
      limit = COUNT_WIDTH'(1);
    end
  end

  assign wait_inc = (wait_count_r < limit) ? wait_count_r + COUNT_WIDTH'(1) : wait_count_r;
  assign expired  = (wait_inc >= limit);

  // Next-state logic for one tick.
  logic       rx_done;
  logic       rx_strobe;
  logic [7:0] rx_value;
  logic       rx_final;
  logic [1:0] tx_status;

  always_comb begin
    phase_nxt      = phase_r;
    listen_nxt     = listen_r;
    talk_nxt       = talk_r;
    cmd_mode_nxt   = cmd_mode_r;
    wait_count_nxt = wait_count_r;
    held_byte_nxt  = held_byte_r;
    held_final_nxt = held_final_r;
    lines_nxt      = lines_r;
    rx_done        = 1'b0;
    rx_strobe      = 1'b0;
    rx_value       = 8'd0;
    rx_final       = 1'b0;
    tx_status      = TX_NONE;

    unique case (phase_r)
      PH_RX_DAV_LOW: begin
        if (!dav_l) begin
          lines_nxt.nrfd = 1'b0;
          held_byte_nxt  = ~bus_l;
          held_final_nxt = ~eoi_l;
          lines_nxt.ndac = 1'b1;
          phase_nxt      = PH_RX_DAV_HIGH;
          wait_count_nxt = '0;
        end else begin
          wait_count_nxt = wait_inc;
          if (expired) begin
            lines_nxt.ndac = 1'b1;
            phase_nxt      = PH_IDLE;
            wait_count_nxt = '0;
          end
        end
      end
      PH_RX_DAV_HIGH: begin
        if (dav_l) begin
          lines_nxt.nrfd = 1'b1;
          rx_done        = 1'b1;
        end else begin
          wait_count_nxt = wait_inc;
          rx_done        = expired;
        end
      end
      PH_TX_NRFD_HIGH: begin
        if (nrfd_l) begin
          lines_nxt.bus = ~held_byte_r;
          if (held_final_r) begin
            lines_nxt.eoi = 1'b0;
          end
          lines_nxt.dav  = 1'b0;
          phase_nxt      = PH_TX_NRFD_LOW;
          wait_count_nxt = '0;
        end else begin
          wait_count_nxt = wait_inc;
          if (expired) begin
            tx_status      = TX_TIMEOUT;
            phase_nxt      = PH_IDLE;
            wait_count_nxt = '0;
          end
        end
      end
      PH_TX_NRFD_LOW, PH_TX_NDAC_HIGH: begin
        if ((phase_r == PH_TX_NRFD_LOW) ? !nrfd_l : ndac_l) begin
          if (phase_r == PH_TX_NRFD_LOW) begin
            phase_nxt = PH_TX_NDAC_HIGH;
          end else begin
            lines_nxt.dav = 1'b1;
            lines_nxt.bus = BUS_RELEASED;
            if (held_final_r) begin
              lines_nxt.eoi = 1'b1;
            end
            tx_status = TX_SENT;
            phase_nxt = PH_IDLE;
          end
          wait_count_nxt = '0;
        end else begin
          wait_count_nxt = wait_inc;
          if (expired) begin
            lines_nxt.dav  = 1'b1;
            lines_nxt.bus  = BUS_RELEASED;
            lines_nxt.eoi  = 1'b1;
            tx_status      = TX_TIMEOUT;
            phase_nxt      = PH_IDLE;
            wait_count_nxt = '0;
          end
        end
      end
      default: begin
        wait_count_nxt = '0;
        phase_nxt      = PH_IDLE;
        if (!ifc_l) begin
          listen_nxt = 1'b0;
          talk_nxt   = 1'b0;
          lines_nxt  = LINES_RELEASED;
        end else if (!atn_l || listen_r) begin
          cmd_mode_nxt   = !atn_l;
          lines_nxt.ndac = 1'b0;
          lines_nxt.nrfd = 1'b1;
          phase_nxt      = PH_RX_DAV_LOW;
        end else if (talk_r && offer) begin
          held_byte_nxt  = tx_val;
          held_final_nxt = in_last_r;
          tx_status      = TX_TAKEN;
          phase_nxt      = PH_TX_NRFD_HIGH;
        end
      end
    endcase

    // A finished receive is either a bus command or a data byte.
    if (rx_done) begin
      if (cmd_mode_r) begin
        priority if (held_byte_nxt == CMD_UNLISTEN) begin
          listen_nxt    = 1'b0;
          lines_nxt.bus = BUS_RELEASED;
        end else if (held_byte_nxt == CMD_UNTALK) begin
          talk_nxt      = 1'b0;
          lines_nxt.bus = BUS_RELEASED;
        end else if (held_byte_nxt == {CMD_LISTEN_GRP, dev_addr_r}) begin
          listen_nxt = 1'b1;
          talk_nxt   = 1'b0;
        end else if (held_byte_nxt == {CMD_TALK_GRP, dev_addr_r}) begin
          talk_nxt   = 1'b1;
          listen_nxt = 1'b0;
        end else begin
          listen_nxt = listen_nxt;
        end
      end else begin
        rx_strobe = 1'b1;
        rx_value  = held_byte_nxt;
        rx_final  = held_final_nxt;
      end
      phase_nxt      = PH_IDLE;
      wait_count_nxt = '0;
    end
  end

  // State update on each processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      listen_r     <= 1'b0;
      talk_r       <= 1'b0;
      cmd_mode_r   <= 1'b0;
      wait_count_r <= '0;
      held_byte_r  <= 8'd0;
      held_final_r <= 1'b0;
      lines_r      <= LINES_RELEASED;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      listen_r     <= listen_nxt;
      talk_r       <= talk_nxt;
      cmd_mode_r   <= cmd_mode_nxt;
      wait_count_r <= wait_count_nxt;
      held_byte_r  <= held_byte_nxt;
      held_final_r <= held_final_nxt;
      lines_r      <= lines_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {7'd0, tx_status, talk_nxt, listen_nxt, rx_value, rx_strobe,
                     lines_nxt.bus, lines_nxt.eoi, lines_nxt.ndac, lines_nxt.nrfd,
                     lines_nxt.dav};
      out_last_r <= rx_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Assertions.
  `GPIB3W_ASSERT_IMPL(a_idle_count_clear, clk, rst_n, phase_r == PH_IDLE, wait_count_r == '0)
  `GPIB3W_ASSERT_IMPL(a_flags_exclusive, clk, rst_n, 1'b1, !(listen_r && talk_r))
  `GPIB3W_ASSERT_IMPL(a_rx_holds_ndac, clk, rst_n, phase_r == PH_RX_DAV_LOW, !lines_r.ndac)
  `GPIB3W_ASSERT_IMPL(a_tx_holds_dav, clk, rst_n,
                      phase_r == PH_TX_NRFD_LOW || phase_r == PH_TX_NDAC_HIGH, !lines_r.dav)
  `GPIB3W_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_r)

endmodule

`default_nettype wire

@@ sim/gpib_three_wire_handshake_tb.sv @@
// ----------------------------------------------------------------------------
// GPIB three-wire handshake testbench
// Streams ticks of sampled bus lines into the handshake device. A tick-level
// predictor of the listener and talker computes the drive levels and events
// that each tick must produce, and the results are compared field by field.
// Traffic is mostly well-formed command, receive and send handshakes with
// random waits, mixed with IFC ticks and noise, under several register
// settings. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module gpib_three_wire_handshake_tb;
  import gpib3w_pkg::*;

  localparam logic [31:0] COUNT_MAX = 32'h00FF_FFFF;
  localparam int          HOLD_CYCLES = 300;

  // One tick of sampled lines; the low 23 bits travel on in_tdata, tx_last on in_tlast.
  typedef struct packed {
    logic       tx_last;
    logic [7:0] tx_value;
    logic       tx_offer;
    logic [7:0] bus;
    logic       eoi;
    logic       ndac;
    logic       nrfd;
    logic       dav;
    logic       atn;
    logic       ifc;
  } tick_t;

  // One result; the low 25 bits travel on out_tdata, rx_final on out_tlast.
  typedef struct packed {
    logic       rx_final;
    logic [1:0] tx_status;
    logic       talking;
    logic       listening;
    logic [7:0] rx_value;
    logic       rx_strobe;
    logic [7:0] bus;
    logic       eoi;
    logic       ndac;
    logic       nrfd;
    logic       dav;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_DEVICE_ADDRESS;
  logic [23:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // ifc, atn, dav, nrfd, ndac, eoi, bus[7:0], offer, value[7:0]
  logic        in_tlast = 1'b0; // tx_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // dav, nrfd, ndac, eoi, bus[7:0], strobe, value[7:0], lsn, tlk, status[1:0]
  logic        out_tlast;       // rx_final

  gpib_three_wire_handshake dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Stimulus and scoreboard storage.
  tick_t   line_ticks_q[$];
  result_t bus_outputs_q[$];
  int      mismatch_cnt = 0;
  logic    in_fire = 1'b0;
  logic    bursty = 1'b1;
  int      hold_asked = 0;

  // Predictor copy of the device state and registers.
  logic [4:0]   dev_addr_m;
  logic [23:0]  timeout_m;
  logic [2:0]   phase_m;
  logic         listen_m;
  logic         talk_m;
  logic         cmd_mode_m;
  logic [31:0]  wait_cnt_m;
  logic [7:0]   held_byte_m;
  logic         held_last_m;
  line_drives_t drives_m;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void go_phase(input logic [2:0] p);
    phase_m = p;
    wait_cnt_m = '0;
  endfunction

  // Counts one unmet tick of a wait and reports whether the wait has failed.
  function automatic logic wait_over();
    logic [31:0] limit;
    limit = (timeout_m == '0) ? 32'd1 : {8'd0, timeout_m};
    if (limit > COUNT_MAX) limit = COUNT_MAX;
    if (wait_cnt_m < limit) wait_cnt_m = wait_cnt_m + 32'd1;
    return wait_cnt_m >= limit;
  endfunction

  // Advances the device by one tick and returns the drives and events it shows.
  function automatic result_t handshake_tick(input tick_t t);
    result_t r;
    logic    rx_done;
    r = '0;
    r.tx_status = TX_NONE;
    rx_done = 1'b0;
    case (phase_m)
      PH_RX_DAV_LOW: begin
        if (!t.dav) begin
          drives_m.nrfd = 1'b0;
          held_byte_m = ~t.bus;
          held_last_m = ~t.eoi;
          drives_m.ndac = 1'b1;
          go_phase(PH_RX_DAV_HIGH);
        end else if (wait_over()) begin
          drives_m.ndac = 1'b1;
          go_phase(PH_IDLE);
        end
      end
      PH_RX_DAV_HIGH: begin
        if (t.dav) begin
          drives_m.nrfd = 1'b1;
          rx_done = 1'b1;
        end else if (wait_over()) begin
          rx_done = 1'b1;
        end
      end
      PH_TX_NRFD_HIGH: begin
        if (t.nrfd) begin
          drives_m.bus = ~held_byte_m;
          if (held_last_m) drives_m.eoi = 1'b0;
          drives_m.dav = 1'b0;
          go_phase(PH_TX_NRFD_LOW);
        end else if (wait_over()) begin
          r.tx_status = TX_TIMEOUT;
          go_phase(PH_IDLE);
        end
      end
      PH_TX_NRFD_LOW: begin
        if (!t.nrfd) begin
          go_phase(PH_TX_NDAC_HIGH);
        end else if (wait_over()) begin
          drives_m.dav = 1'b1;
          drives_m.bus = BUS_RELEASED;
          drives_m.eoi = 1'b1;
          r.tx_status = TX_TIMEOUT;
          go_phase(PH_IDLE);
        end
      end
      PH_TX_NDAC_HIGH: begin
        if (t.ndac) begin
          drives_m.dav = 1'b1;
          drives_m.bus = BUS_RELEASED;
          if (held_last_m) drives_m.eoi = 1'b1;
          r.tx_status = TX_SENT;
          go_phase(PH_IDLE);
        end else if (wait_over()) begin
          drives_m.dav = 1'b1;
          drives_m.bus = BUS_RELEASED;
          drives_m.eoi = 1'b1;
          r.tx_status = TX_TIMEOUT;
          go_phase(PH_IDLE);
        end
      end
      default: begin
        // Only the idle phase looks at IFC, ATN and the offer.
        if (!t.ifc) begin
          listen_m = 1'b0;
          talk_m = 1'b0;
          drives_m = LINES_RELEASED;
          go_phase(PH_IDLE);
        end else if (!t.atn || listen_m) begin
          cmd_mode_m = !t.atn;
          drives_m.ndac = 1'b0;
          drives_m.nrfd = 1'b1;
          go_phase(PH_RX_DAV_LOW);
        end else if (talk_m && t.tx_offer) begin
          held_byte_m = t.tx_value;
          held_last_m = t.tx_last;
          r.tx_status = TX_TAKEN;
          go_phase(PH_TX_NRFD_HIGH);
        end else begin
          go_phase(PH_IDLE);
        end
      end
    endcase

    // A finished receive is either a bus command or a data byte.
    if (rx_done) begin
      if (cmd_mode_m) begin
        if (held_byte_m == CMD_UNLISTEN) begin
          listen_m = 1'b0;
          drives_m.bus = BUS_RELEASED;
        end else if (held_byte_m == CMD_UNTALK) begin
          talk_m = 1'b0;
          drives_m.bus = BUS_RELEASED;
        end else if (held_byte_m == {CMD_LISTEN_GRP, dev_addr_m}) begin
          listen_m = 1'b1;
          talk_m = 1'b0;
        end else if (held_byte_m == {CMD_TALK_GRP, dev_addr_m}) begin
          talk_m = 1'b1;
          listen_m = 1'b0;
        end
      end else begin
        r.rx_strobe = 1'b1;
        r.rx_value = held_byte_m;
        r.rx_final = held_last_m;
      end
      go_phase(PH_IDLE);
    end

    r.dav = drives_m.dav;
    r.nrfd = drives_m.nrfd;
    r.ndac = drives_m.ndac;
    r.eoi = drives_m.eoi;
    r.bus = drives_m.bus;
    r.listening = listen_m;
    r.talking = talk_m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic tick_t rand_tick();
    logic [31:0] v;
    v = $urandom();
    return v[23:0];
  endfunction

  function automatic tick_t start_tick(input logic ifc, input logic atn, input logic offer);
    tick_t t;
    t = rand_tick();
    t.ifc = ifc;
    t.atn = atn;
    t.tx_offer = offer;
    return t;
  endfunction

  function automatic int pick_wait();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 20);
  endfunction

  // Talker side of one byte transfer as seen on the bus, with unmet ticks before each edge.
  task automatic talker_byte(input logic [7:0] value, input logic eoi_mark,
                             input int w_low, input int w_high);
    tick_t t;
    repeat (w_low) begin
      t = rand_tick();
      t.dav = 1'b1;
      line_ticks_q.push_back(t);
    end
    t = rand_tick();
    t.dav = 1'b0;
    t.bus = ~value;
    t.eoi = ~eoi_mark;
    line_ticks_q.push_back(t);
    repeat (w_high) begin
      t = rand_tick();
      t.dav = 1'b0;
      line_ticks_q.push_back(t);
    end
    t = rand_tick();
    t.dav = 1'b1;
    line_ticks_q.push_back(t);
  endtask

  task automatic issue_command(input logic [7:0] cmd, input int w_low, input int w_high);
    line_ticks_q.push_back(start_tick(1'b1, 1'b0, 1'b0));
    talker_byte(cmd, 1'b0, w_low, w_high);
  endtask

  task automatic receive_byte(input logic [7:0] value, input logic eoi_mark,
                              input int w_low, input int w_high);
    line_ticks_q.push_back(start_tick(1'b1, 1'b1, 1'b0));
    talker_byte(value, eoi_mark, w_low, w_high);
  endtask

  // Offer a byte, then play the listeners' NRFD and NDAC replies.
  task automatic send_byte(input logic [7:0] value, input logic last_byte,
                           input int w_ready, input int w_taken, input int w_accept);
    tick_t t;
    t = start_tick(1'b1, 1'b1, 1'b1);
    t.tx_value = value;
    t.tx_last = last_byte;
    line_ticks_q.push_back(t);
    repeat (w_ready) begin
      t = rand_tick();
      t.nrfd = 1'b0;
      line_ticks_q.push_back(t);
    end
    t = rand_tick();
    t.nrfd = 1'b1;
    line_ticks_q.push_back(t);
    repeat (w_taken) begin
      t = rand_tick();
      t.nrfd = 1'b1;
      line_ticks_q.push_back(t);
    end
    t = rand_tick();
    t.nrfd = 1'b0;
    line_ticks_q.push_back(t);
    repeat (w_accept) begin
      t = rand_tick();
      t.ndac = 1'b0;
      line_ticks_q.push_back(t);
    end
    t = rand_tick();
    t.ndac = 1'b1;
    line_ticks_q.push_back(t);
  endtask

  // Mostly well-formed handshakes with random content; the rest is IFC and noise.
  task automatic queue_bus_traffic(input int n_ticks, input logic [4:0] addr);
    logic [7:0] cmd;
    int         kind;
    tick_t      t;
    while (line_ticks_q.size() < n_ticks) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        case ($urandom_range(0, 5))
          0: cmd = CMD_UNLISTEN;
          1: cmd = CMD_UNTALK;
          2: cmd = {CMD_LISTEN_GRP, addr};
          3: cmd = {CMD_TALK_GRP, addr};
          4: cmd = {($urandom_range(0, 1) ? CMD_LISTEN_GRP : CMD_TALK_GRP),
                    5'($urandom_range(0, 31))};
          default: cmd = 8'($urandom_range(0, 255));
        endcase
        issue_command(cmd, pick_wait(), pick_wait());
      end else if (kind < 50) begin
        receive_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     pick_wait(), pick_wait());
      end else if (kind < 80) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  pick_wait(), pick_wait(), pick_wait());
      end else if (kind < 86) begin
        t = rand_tick();
        t.ifc = 1'b0;
        line_ticks_q.push_back(t);
      end else begin
        repeat ($urandom_range(1, 4)) line_ticks_q.push_back(rand_tick());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes and phase boundaries
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_DEVICE_ADDRESS) dev_addr_m = value[4:0];
    else timeout_m = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every tick is sent and every result has arrived, then let the pipe empty.
  task automatic drain_all();
    while (line_ticks_q.size() != 0 || in_tvalid || bus_outputs_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one transfer per accepted tick, random gaps between items.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (bursty && $urandom_range(0, 13) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        in_tvalid <= 1'b0;
      end else if (line_ticks_q.size() != 0) begin
        tick_t t;
        t = line_ticks_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, t[22:0]};
        in_tlast <= t.tx_last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  int hold_served = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (bursty && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer, then predicts for each tick transfer.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = {out_tlast, out_tdata[24:0]};
        if (bus_outputs_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatch_cnt++;
        end else begin
          want = bus_outputs_q.pop_front();
          compare_field("dav_drive", want.dav, seen.dav);
          compare_field("nrfd_drive", want.nrfd, seen.nrfd);
          compare_field("ndac_drive", want.ndac, seen.ndac);
          compare_field("eoi_drive", want.eoi, seen.eoi);
          compare_field("bus_drive", want.bus, seen.bus);
          compare_field("rx_strobe", want.rx_strobe, seen.rx_strobe);
          compare_field("rx_value", want.rx_value, seen.rx_value);
          compare_field("rx_final", want.rx_final, seen.rx_final);
          compare_field("listening", want.listening, seen.listening);
          compare_field("talking", want.talking, seen.talking);
          compare_field("tx_status", want.tx_status, seen.tx_status);
        end
      end
      if (in_tvalid && in_tready) begin
        bus_outputs_q.push_back(handshake_tick({in_tlast, in_tdata[22:0]}));
        in_fire = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    tick_t t;
    dev_addr_m = DEVICE_ADDRESS_RST;
    timeout_m = TIMEOUT_RST;
    phase_m = PH_IDLE;
    listen_m = 1'b0;
    talk_m = 1'b0;
    cmd_mode_m = 1'b0;
    wait_cnt_m = '0;
    held_byte_m = '0;
    held_last_m = 1'b0;
    drives_m = LINES_RELEASED;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: quiet bus, IFC, listen and receive extremes, talk and send extremes,
    // untalk, and an offer while not addressed.
    t = '1;
    t.tx_offer = 1'b0;
    line_ticks_q.push_back(t);
    t.ifc = 1'b0;
    line_ticks_q.push_back(t);
    issue_command({CMD_LISTEN_GRP, DEVICE_ADDRESS_RST}, 0, 0);
    receive_byte(8'h00, 1'b1, 0, 0);
    receive_byte(8'hFF, 1'b0, 0, 0);
    issue_command({CMD_TALK_GRP, DEVICE_ADDRESS_RST}, 0, 0);
    send_byte(8'hFF, 1'b1, 0, 0, 0);
    send_byte(8'h00, 1'b0, 0, 0, 0);
    issue_command(CMD_UNTALK, 0, 0);
    line_ticks_q.push_back(start_tick(1'b1, 1'b1, 1'b1));
    drain_all();

    // Highest address, where the unlisten and untalk codes shadow my listen and talk
    // addresses, and the shortest timeout, so every unmet tick fails its wait.
    write_reg(REG_DEVICE_ADDRESS, 24'd31);
    write_reg(REG_HANDSHAKE_TIMEOUT, 24'd1);
    queue_bus_traffic(230, 5'd31);
    drain_all();

    // Zero timeout behaves as one; no idling on either side here.
    bursty = 1'b0;
    write_reg(REG_DEVICE_ADDRESS, 24'd0);
    write_reg(REG_HANDSHAKE_TIMEOUT, 24'd0);
    queue_bus_traffic(230, 5'd0);
    drain_all();

    // Largest timeout: waits never fail.
    bursty = 1'b1;
    dev_addr_m = 5'($urandom_range(0, 31));
    write_reg(REG_DEVICE_ADDRESS, {19'd0, dev_addr_m});
    write_reg(REG_HANDSHAKE_TIMEOUT, 24'hFF_FFFF);
    queue_bus_traffic(230, dev_addr_m);
    drain_all();

    // Short timeouts, with the receiver holding off while ticks are still waiting to go in.
    dev_addr_m = 5'($urandom_range(0, 31));
    write_reg(REG_DEVICE_ADDRESS, {19'd0, dev_addr_m});
    write_reg(REG_HANDSHAKE_TIMEOUT, 24'($urandom_range(2, 12)));
    queue_bus_traffic(230, dev_addr_m);
    hold_asked = hold_asked + 1;
    drain_all();

    // Final stretch at full rate.
    bursty = 1'b0;
    dev_addr_m = 5'($urandom_range(0, 31));
    write_reg(REG_DEVICE_ADDRESS, {19'd0, dev_addr_m});
    write_reg(REG_HANDSHAKE_TIMEOUT, 24'($urandom_range(5, 30)));
    queue_bus_traffic(230, dev_addr_m);
    drain_all();

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
